### src/amp_pkg.sv
// Package for the adaptive max pooling block: sizes, register indexes,
// column memory entry type and the size clamp helper.
// No dependencies.
package amp_pkg;

	// Geometry
	localparam int MAX_DIM     = 1024;
	localparam int DIM_BITS    = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
	localparam int IDX_BITS    = $clog2(MAX_DIM);       // index into a dimension
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = 16;
	localparam int FRAC_BITS   = 12;                    // Q4.12 gain
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
	localparam int VALUE_BITS  = PROD_BITS - FRAC_BITS;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;

	// Divider runs one quotient bit per cycle
	localparam int DIV_STEPS   = DIM_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN       = 3'd4;

	localparam logic [DIM_BITS-1:0]  DIM_ONE  = DIM_BITS'(1);
	localparam logic [DIM_BITS-1:0]  DIM_MAX  = DIM_BITS'(MAX_DIM);
	localparam logic signed [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(4096);

	typedef logic [DIM_BITS-1:0] dim_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	// One column memory entry: running max and its in-pool offsets
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] best;
		idx_t                          row;
		idx_t                          col;
	} col_entry_t;

	// Zero reads as one, oversize reads as MAX_DIM
	function automatic dim_t clamp_dim(input dim_t v);
		dim_t r;
		r = v;
		if (v == '0) r = DIM_ONE;
		else if (v > DIM_MAX) r = DIM_MAX;
		return r;
	endfunction

endpackage

### src/amp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with
// registered read data. No dependencies.
module amp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/adaptive_max_pool_forward.sv
// A result for a pool passes the column memory read, compare/write, gain
// multiply and output register after the beat of the pool's last pixel.
// Throughput: one sample per cycle unless the output stalls; after any
// register write, input stalls while the bit-serial dividers redo pool sizes.
// Reset: registers to defaults, pool counters to zero; column memory is not
// cleared (every entry is written by its pool's first pixel before use).
module adaptive_max_pool_forward (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [amp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [amp_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [amp_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [amp_pkg::VALUE_BITS-1:0]  pooled_value,
	output logic [amp_pkg::IDX_BITS-1:0]           out_row,
	output logic [amp_pkg::IDX_BITS-1:0]           out_col,
	output logic [amp_pkg::IDX_BITS-1:0]           arg_row,
	output logic [amp_pkg::IDX_BITS-1:0]           arg_col,
	output logic                                   image_end
);
	import amp_pkg::*;

	// ---------------- configuration registers ----------------
	dim_t in_height_q, in_width_q, out_height_q, out_width_q;
	logic signed [GAIN_BITS-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q  <= DIM_ONE;
			in_width_q   <= DIM_ONE;
			out_height_q <= DIM_ONE;
			out_width_q  <= DIM_ONE;
			gain_q       <= GAIN_UNITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IN_HEIGHT:  in_height_q  <= cfg_data[DIM_BITS-1:0];
				REG_IN_WIDTH:   in_width_q   <= cfg_data[DIM_BITS-1:0];
				REG_OUT_HEIGHT: out_height_q <= cfg_data[DIM_BITS-1:0];
				REG_OUT_WIDTH:  out_width_q  <= cfg_data[DIM_BITS-1:0];
				REG_GAIN:       gain_q       <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pool size divider ----------------
	// Two restoring dividers (rows, columns) share one step counter.
	dim_t ih_c, iw_c, oh_c, ow_c;
	logic div_load_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	dim_t r_quo_q, c_quo_q, r_rem_q, c_rem_q, r_den_q, c_den_q;
	logic [DIM_BITS:0] r_trial, c_trial;
	logic r_ge, c_ge;
	dim_t r_rem_nx, c_rem_nx, r_quo_nx, c_quo_nx;
	logic div_busy;

	// pending results, taken at the next image start
	dim_t pend_rq_q, pend_cq_q, pend_rows_q, pend_cols_q;
	idx_t pend_rr_q, pend_cr_q;

	always_comb begin
		ih_c = clamp_dim(in_height_q);
		iw_c = clamp_dim(in_width_q);
		oh_c = clamp_dim(out_height_q);
		ow_c = clamp_dim(out_width_q);
		if (oh_c > ih_c) oh_c = ih_c;
		if (ow_c > iw_c) ow_c = iw_c;
	end

	always_comb begin
		r_trial  = {r_rem_q, r_quo_q[DIM_BITS-1]};
		c_trial  = {c_rem_q, c_quo_q[DIM_BITS-1]};
		r_ge     = r_trial >= {1'b0, r_den_q};
		c_ge     = c_trial >= {1'b0, c_den_q};
		r_rem_nx = r_ge ? DIM_BITS'(r_trial - {1'b0, r_den_q}) : r_trial[DIM_BITS-1:0];
		c_rem_nx = c_ge ? DIM_BITS'(c_trial - {1'b0, c_den_q}) : c_trial[DIM_BITS-1:0];
		r_quo_nx = {r_quo_q[DIM_BITS-2:0], r_ge};
		c_quo_nx = {c_quo_q[DIM_BITS-2:0], c_ge};
	end

	assign div_busy = div_load_q || (div_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_load_q  <= 1'b0;
			div_cnt_q   <= '0;
			pend_rq_q   <= DIM_ONE;
			pend_cq_q   <= DIM_ONE;
			pend_rr_q   <= '0;
			pend_cr_q   <= '0;
			pend_rows_q <= DIM_ONE;
			pend_cols_q <= DIM_ONE;
		end else begin
			div_load_q <= cfg_we;
			if (div_load_q) begin
				div_cnt_q <= DIV_CNT_BITS'(DIV_STEPS);
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == DIV_CNT_BITS'(1)) begin
					pend_rq_q   <= r_quo_nx;
					pend_cq_q   <= c_quo_nx;
					pend_rr_q   <= r_rem_nx[IDX_BITS-1:0];
					pend_cr_q   <= c_rem_nx[IDX_BITS-1:0];
					pend_rows_q <= r_den_q;
					pend_cols_q <= c_den_q;
				end
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (div_load_q) begin
			r_quo_q <= ih_c;
			c_quo_q <= iw_c;
			r_den_q <= oh_c;
			c_den_q <= ow_c;
			r_rem_q <= '0;
			c_rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			r_quo_q <= r_quo_nx;
			c_quo_q <= c_quo_nx;
			r_rem_q <= r_rem_nx;
			c_rem_q <= c_rem_nx;
		end
	end

	// ---------------- pipeline flow control ----------------
	logic valid_s1, valid_s2, out_valid_q;
	logic out_load, s2_adv, s1_adv, accept;

	assign out_load = !out_valid_q || !out_stall;
	assign s2_adv   = !valid_s2 || out_load;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign in_stall = !s1_adv || div_busy;
	assign accept   = in_valid && !in_stall;

	// ---------------- pool position counters ----------------
	idx_t rpi_q, rip_q, cpi_q, cip_q;
	dim_t act_rq_q, act_cq_q, act_rows_q, act_cols_q;
	idx_t act_rr_q, act_cr_q;
	dim_t rq_e, cq_e, rows_e, cols_e;
	idx_t rr_e, cr_e;
	logic at_start;
	dim_t rlen, clen, rpi_inc, rip_inc, cpi_inc, cip_inc;
	logic emit_c, last_c, first_c;

	always_comb begin
		at_start = (rpi_q == '0) && (rip_q == '0) && (cpi_q == '0) && (cip_q == '0);
		// first beat of an image uses the freshly latched division
		rq_e   = at_start ? pend_rq_q   : act_rq_q;
		cq_e   = at_start ? pend_cq_q   : act_cq_q;
		rr_e   = at_start ? pend_rr_q   : act_rr_q;
		cr_e   = at_start ? pend_cr_q   : act_cr_q;
		rows_e = at_start ? pend_rows_q : act_rows_q;
		cols_e = at_start ? pend_cols_q : act_cols_q;
		rlen   = (rpi_q < rr_e) ? rq_e + 1'b1 : rq_e;
		clen   = (cpi_q < cr_e) ? cq_e + 1'b1 : cq_e;
		rpi_inc = {1'b0, rpi_q} + 1'b1;
		rip_inc = {1'b0, rip_q} + 1'b1;
		cpi_inc = {1'b0, cpi_q} + 1'b1;
		cip_inc = {1'b0, cip_q} + 1'b1;
		first_c = (rip_q == '0) && (cip_q == '0);
		emit_c  = (rip_inc == rlen) && (cip_inc == clen);
		last_c  = (rpi_inc == rows_e) && (cpi_inc == cols_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpi_q      <= '0;
			rip_q      <= '0;
			cpi_q      <= '0;
			cip_q      <= '0;
			act_rq_q   <= DIM_ONE;
			act_cq_q   <= DIM_ONE;
			act_rr_q   <= '0;
			act_cr_q   <= '0;
			act_rows_q <= DIM_ONE;
			act_cols_q <= DIM_ONE;
		end else if (accept) begin
			if (at_start) begin
				act_rq_q   <= pend_rq_q;
				act_cq_q   <= pend_cq_q;
				act_rr_q   <= pend_rr_q;
				act_cr_q   <= pend_cr_q;
				act_rows_q <= pend_rows_q;
				act_cols_q <= pend_cols_q;
			end
			// raster walk: column offset, column pool, row offset, row pool
			if (cip_inc >= clen) begin
				cip_q <= '0;
				if (cpi_inc >= cols_e) begin
					cpi_q <= '0;
					if (rip_inc >= rlen) begin
						rip_q <= '0;
						rpi_q <= (rpi_inc >= rows_e) ? '0 : rpi_inc[IDX_BITS-1:0];
					end else begin
						rip_q <= rip_inc[IDX_BITS-1:0];
					end
				end else begin
					cpi_q <= cpi_inc[IDX_BITS-1:0];
				end
			end else begin
				cip_q <= cip_inc[IDX_BITS-1:0];
			end
		end
	end

	// ---------------- column memory ----------------
	col_entry_t rd_entry, old_entry, new_entry, lw_entry_q;
	idx_t lw_addr_q;
	logic lw_valid_q, mem_we;

	// stage 1 registers
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	idx_t addr_s1, rip_s1, cip_s1, rpi_s1;
	logic first_s1, emit_s1, last_s1;

	amp_ram #(
		.WIDTH($bits(col_entry_t)),
		.DEPTH(MAX_DIM)
	) u_col_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_s1),
		.wdata (new_entry),
		.re    (accept),
		.raddr (cpi_q),
		.rdata (rd_entry)
	);

	// forward the latest write over a read that raced it
	always_comb begin
		old_entry = (lw_valid_q && lw_addr_q == addr_s1) ? lw_entry_q : rd_entry;
		if (first_s1) begin
			new_entry.best = sample_s1;
			new_entry.row  = '0;
			new_entry.col  = '0;
		end else if (sample_s1 > old_entry.best) begin
			new_entry.best = sample_s1;
			new_entry.row  = rip_s1;
			new_entry.col  = cip_s1;
		end else begin
			new_entry = old_entry;
		end
		mem_we = valid_s1 && s1_adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			lw_valid_q <= 1'b0;
		end else begin
			if (s1_adv) valid_s1 <= accept;
			if (mem_we) lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			addr_s1   <= cpi_q;
			rip_s1    <= rip_q;
			cip_s1    <= cip_q;
			rpi_s1    <= rpi_q;
			first_s1  <= first_c;
			emit_s1   <= emit_c;
			last_s1   <= last_c;
		end
		if (mem_we) begin
			lw_addr_q  <= addr_s1;
			lw_entry_q <= new_entry;
		end
	end

	// ---------------- stage 2: finished pool ----------------
	col_entry_t entry_s2;
	idx_t out_row_s2, out_col_s2;
	logic last_s2;
	logic signed [PROD_BITS-1:0] product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s1 && emit_s1) begin
			entry_s2   <= new_entry;
			out_row_s2 <= rpi_s1;
			out_col_s2 <= addr_s1;
			last_s2    <= last_s1;
		end
	end

	// gain multiply, floor by arithmetic shift
	assign product = entry_s2.best * gain_q;

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			pooled_value <= product[PROD_BITS-1:FRAC_BITS];
			out_row      <= out_row_s2;
			out_col      <= out_col_s2;
			arg_row      <= entry_s2.row;
			arg_col      <= entry_s2.col;
			image_end    <= last_s2;
		end
	end

	assign out_valid = out_valid_q;

endmodule
